[sv/nsr_pkg.sv]
// Shared constants, types and codes for the Newton square-root block.
package nsr_pkg;

  localparam int VALUE_W        = 32;
  localparam int FRAC_W         = 16;
  localparam int NUM_W          = VALUE_W - 1 + FRAC_W;
  localparam int ROOT_W         = 24;
  localparam int STATUS_W       = 2;
  localparam int TOL_W          = 16;
  localparam int MAX_ITERATIONS = 32;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int DIV_CNT_W      = $clog2(NUM_W + 1);

  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(66);
  localparam logic [ROOT_W-1:0] ROOT_MAX  = {ROOT_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK  = 2'd0,
    ST_NEG = 2'd1,
    ST_TOL = 2'd2,
    ST_CAP = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/nsr_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module nsr_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nsr_pkg::div_ctrl_t       ctrl,
  input  logic [nsr_pkg::NUM_W-1:0] numer,
  input  logic [nsr_pkg::NUM_W-1:0] denom,
  output nsr_pkg::div_stat_t       stat,
  output logic [nsr_pkg::NUM_W-1:0] quot
);

  logic                            busy_r;
  logic                            done_r;
  logic [nsr_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [nsr_pkg::NUM_W-1:0]       rem_r;
  logic [nsr_pkg::NUM_W-1:0]       quo_r;
  logic [nsr_pkg::NUM_W-1:0]       den_r;

  logic [nsr_pkg::NUM_W:0]         trial;
  logic [nsr_pkg::NUM_W:0]         diff;
  logic                            qbit;
  logic [nsr_pkg::NUM_W-1:0]       rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[nsr_pkg::NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    qbit    = ~diff[nsr_pkg::NUM_W];
    rem_nxt = qbit ? diff[nsr_pkg::NUM_W-1:0] : trial[nsr_pkg::NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !ctrl.start && (cnt_r == nsr_pkg::DIV_CNT_W'(1));
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= nsr_pkg::DIV_CNT_W'(nsr_pkg::NUM_W);
        rem_r  <= '0;
        quo_r  <= numer;
        den_r  <= denom;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[nsr_pkg::NUM_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == nsr_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && cnt_r == '0)
    else $error("divider done while still busy");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> busy_r && cnt_r == nsr_pkg::DIV_CNT_W'(nsr_pkg::NUM_W))
    else $error("divider did not start");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with zero count");

endmodule

[sv/newton_square_root.sv]
// Top level: Newton-Raphson square root sequencer around a shared divider.
// Negative input, zero tolerance or zero input: the result goes from S_IDLE through S_DONE
// to out_tvalid without the divider. Otherwise each Newton step starts the shared divider,
// takes 47 quotient bits from it and updates the estimate, for up to MAX_ITERATIONS steps.
// Throughput: one item at a time; in_tready returns when the result is registered.
// Reset (rst_n, synchronous, low): sequencer idle, no result pending, tolerance 66.
module newton_square_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [nsr_pkg::TOL_W-1:0]     cfg_wr_data,  // tolerance
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [nsr_pkg::VALUE_W-1:0]   in_tdata,     // value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [nsr_pkg::ROOT_W-1:0]    out_tdata,    // root
  output logic [nsr_pkg::STATUS_W-1:0]  out_tuser     // status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t                          state_r;
  logic [nsr_pkg::TOL_W-1:0]       tol_r;
  logic [nsr_pkg::NUM_W-1:0]       num_r;
  logic [nsr_pkg::NUM_W-1:0]       x_r;
  logic [nsr_pkg::ITER_W-1:0]      iter_r;
  logic                            div_start_r;
  logic [nsr_pkg::ROOT_W-1:0]      res_root_r;
  nsr_pkg::status_t                res_status_r;
  logic                            out_tvalid_r;
  logic [nsr_pkg::ROOT_W-1:0]      out_root_r;
  nsr_pkg::status_t                out_status_r;

  nsr_pkg::div_ctrl_t              div_ctrl;
  nsr_pkg::div_stat_t              div_stat;
  logic [nsr_pkg::NUM_W-1:0]       quot;

  logic [nsr_pkg::NUM_W:0]         sum;
  logic [nsr_pkg::NUM_W-1:0]       nx;
  logic [nsr_pkg::NUM_W-1:0]       delta;
  logic                            conv;
  logic [nsr_pkg::ROOT_W-1:0]      nx_sat;
  logic [nsr_pkg::NUM_W-1:0]       x_init;
  logic                            in_xfer;

  assign div_ctrl.start = div_start_r;

  nsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .numer (num_r),
    .denom (x_r),
    .stat  (div_stat),
    .quot  (quot)
  );

  always_comb begin
    sum    = {1'b0, x_r} + {1'b0, quot};
    nx     = sum[nsr_pkg::NUM_W:1];
    delta  = (nx >= x_r) ? (nx - x_r) : (x_r - nx);
    conv   = delta < nsr_pkg::NUM_W'(tol_r);
    nx_sat = (nx > nsr_pkg::NUM_W'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                       : nx[nsr_pkg::ROOT_W-1:0];
    x_init = nsr_pkg::NUM_W'(in_tdata[nsr_pkg::VALUE_W-2:1]);
    if (x_init == '0) begin
      x_init = nsr_pkg::NUM_W'(1);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= nsr_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      iter_r       <= '0;
    end else begin
      div_start_r <= ((state_r == S_IDLE) && in_xfer && !in_tdata[nsr_pkg::VALUE_W-1] &&
                      (tol_r != '0) && (in_tdata != '0)) ||
                     ((state_r == S_DIV) && div_stat.done && !conv &&
                      (iter_r != nsr_pkg::ITER_W'(nsr_pkg::MAX_ITERATIONS - 1)));
      if ((state_r == S_DONE) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            res_root_r <= '0;
            if (in_tdata[nsr_pkg::VALUE_W-1]) begin
              res_status_r <= nsr_pkg::ST_NEG;
              state_r      <= S_DONE;
            end else if (tol_r == '0) begin
              res_status_r <= nsr_pkg::ST_TOL;
              state_r      <= S_DONE;
            end else if (in_tdata == '0) begin
              res_status_r <= nsr_pkg::ST_OK;
              state_r      <= S_DONE;
            end else begin
              num_r       <= {in_tdata[nsr_pkg::VALUE_W-2:0], {nsr_pkg::FRAC_W{1'b0}}};
              x_r         <= x_init;
              iter_r      <= '0;
              state_r     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            x_r    <= nx;
            iter_r <= iter_r + 1'b1;
            if (conv) begin
              res_root_r   <= nx_sat;
              res_status_r <= nsr_pkg::ST_OK;
              state_r      <= S_DONE;
            end else if (iter_r == nsr_pkg::ITER_W'(nsr_pkg::MAX_ITERATIONS - 1)) begin
              res_root_r   <= '0;
              res_status_r <= nsr_pkg::ST_CAP;
              state_r      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_root_r   <= res_root_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_root_r;
  assign out_tuser  = out_status_r;

  a_err_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_status_r != nsr_pkg::ST_OK |-> out_root_r == '0)
    else $error("nonzero root with error status");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> !div_stat.busy && state_r == S_DIV)
    else $error("divider started while busy");

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_stat.busy && !div_stat.done)
    else $error("divider active while idle");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> iter_r < nsr_pkg::ITER_W'(nsr_pkg::MAX_ITERATIONS))
    else $error("iteration count past cap");

endmodule
